// ===== hdl/ile_pkg.sv =====
// Shared constants, types and codes of the indexed list engine.
package ile_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int FUNC_W  = 3;
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FUNC_APPEND = 3'd0;
    localparam func_t FUNC_INSERT = 3'd1;
    localparam func_t FUNC_ERASE  = 3'd2;
    localparam func_t FUNC_READ   = 3'd3;
    localparam func_t FUNC_WRITE  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic idle;
        logic write_new;
        logic move_rd;
        logic move_wr;
        logic read_rd;
        logic occ_inc;
        logic occ_dec;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             in_fire;
        func_t            func;
        logic             fault;
        logic             at_end;
        logic             out_free;
        logic [CNT_W-1:0] occ;
    } sts_t;

endpackage

// ===== hdl/ile_req_if.sv =====
// Request channel of the indexed list engine.
interface ile_req_if;
    import ile_pkg::*;

    logic                     valid;
    logic                     ready;
    func_t                    func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_in;

    modport source (output valid, func, position, data_in, input ready);
    modport sink   (input valid, func, position, data_in, output ready);
endinterface

// ===== hdl/ile_rsp_if.sv =====
// Response channel of the indexed list engine.
interface ile_rsp_if;
    import ile_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_data;
    logic [COUNT_W-1:0]       entry_count;
    logic                     fault;

    modport source (output valid, read_data, entry_count, fault, input ready);
    modport sink   (input valid, read_data, entry_count, fault, output ready);
endinterface

// ===== hdl/ile_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
module ile_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  ile_pkg::sts_t sts,
    output ile_pkg::cmd_t cmd
);
    import ile_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (sts.in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                if (!sts.fault)
                begin
                    unique case (sts.func) inside
                        FUNC_APPEND:
                        begin
                            cmd.write_new = 1'b1;
                            cmd.occ_inc   = 1'b1;
                        end
                        FUNC_WRITE:
                        begin
                            cmd.write_new = 1'b1;
                        end
                        FUNC_READ:
                        begin
                            cmd.read_rd = 1'b1;
                        end
                        FUNC_INSERT, FUNC_ERASE:
                        begin
                            state_next = S_MOVE_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MOVE_RD:
            begin
                if (sts.at_end)
                begin
                    // The gap is open (insert) or closed (erase).
                    if (sts.func == FUNC_INSERT)
                    begin
                        cmd.write_new = 1'b1;
                        cmd.occ_inc   = 1'b1;
                    end
                    else
                    begin
                        cmd.occ_dec = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.move_rd = 1'b1;
                    state_next  = S_MOVE_WR;
                end
            end
            S_MOVE_WR:
            begin
                cmd.move_wr = 1'b1;
                state_next  = S_MOVE_RD;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== hdl/ile_datapath.sv =====
// Datapath: entry memory, occupancy, request registers and the response register.
module ile_datapath (
    input  logic          clk,
    input  logic          rst_n,
    ile_req_if.sink       req,
    ile_rsp_if.source     rsp,
    input  ile_pkg::cmd_t cmd,
    output ile_pkg::sts_t sts
);
    import ile_pkg::*;

    logic [DATA_W-1:0]  mem [DEPTH];
    logic [DATA_W-1:0]  rdata_reg;

    logic [CNT_W-1:0]   occ_reg;
    logic [CNT_W-1:0]   occ_next;

    func_t              func_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [DATA_W-1:0]  data_reg;
    logic               fault_reg;
    logic [IDX_W-1:0]   cursor_reg;
    logic [IDX_W-1:0]   cursor_next;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_fault_reg;

    logic               in_fire;
    logic               full;
    logic [CMP_W-1:0]   pos_c;
    logic [CMP_W-1:0]   occ_c;
    logic               fault_now;
    logic               mem_we;
    logic [DATA_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic               out_free;

    assign in_fire   = req.valid && req.ready;
    assign req.ready = cmd.idle;

    // Request check against the occupancy held before the request.
    assign full  = (occ_reg == CNT_W'(DEPTH));
    assign pos_c = CMP_W'(req.position);
    assign occ_c = CMP_W'(occ_reg);

    always_comb
    begin
        unique case (req.func) inside
            FUNC_APPEND:                        fault_now = full;
            FUNC_INSERT:                        fault_now = full || (pos_c > occ_c);
            FUNC_ERASE, FUNC_READ, FUNC_WRITE:  fault_now = (pos_c >= occ_c);
            default:                            fault_now = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg  <= req.func;
            pos_reg   <= IDX_W'(req.position);
            data_reg  <= req.data_in;
            fault_reg <= fault_now;
        end
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        if (in_fire)
        begin
            if (req.func == FUNC_APPEND || req.func == FUNC_INSERT)
            begin
                cursor_next = IDX_W'(occ_reg);
            end
            else
            begin
                cursor_next = IDX_W'(req.position);
            end
        end
        else if (cmd.move_wr)
        begin
            if (func_reg == FUNC_INSERT)
            begin
                cursor_next = cursor_reg - IDX_W'(1);
            end
            else
            begin
                cursor_next = cursor_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.occ_inc)
        begin
            occ_next = occ_reg + CNT_W'(1);
        end
        else if (cmd.occ_dec)
        begin
            occ_next = occ_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // One write port and one registered read port; a shift moves one entry per read and write.
    assign mem_we    = cmd.write_new || cmd.move_wr;
    assign mem_wdata = cmd.write_new ? data_reg : rdata_reg;
    assign mem_re    = cmd.read_rd || cmd.move_rd;

    always_comb
    begin
        if (cmd.read_rd)
        begin
            mem_raddr = cursor_reg;
        end
        else if (func_reg == FUNC_INSERT)
        begin
            mem_raddr = cursor_reg - IDX_W'(1);
        end
        else
        begin
            mem_raddr = cursor_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cursor_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Response register: a new result may load as the previous beat leaves.
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg  <= (func_reg == FUNC_READ && !fault_reg) ? rdata_reg : '0;
            out_count_reg <= COUNT_W'(occ_reg);
            out_fault_reg <= fault_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_data   = out_data_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.fault       = out_fault_reg;

    assign sts.in_fire  = in_fire;
    assign sts.func     = func_reg;
    assign sts.fault    = fault_reg;
    assign sts.at_end   = (func_reg == FUNC_INSERT) ? (cursor_reg == pos_reg)
                        : ((CNT_W'(cursor_reg) + CNT_W'(1)) == occ_reg);
    assign sts.out_free = out_free;
    assign sts.occ      = occ_reg;
endmodule

// ===== hdl/indexed_list_engine.sv =====
// Top level of the indexed list engine: a bounded ordered list of signed 32-bit words.
//
// The req channel carries one request per beat: func (append, insert, erase,
// read, write), position and data_in. The rsp channel returns one beat per
// request: read_data (zero unless a read succeeds), entry_count after the
// request, and fault when the position is out of range, the list is full
// or func is no known code. A refused request changes nothing.
// Requests are handled one at a time. Append, read, write and any refused
// request pass from the request beat through the execute and done states
// before their response loads into the output register; insert and erase
// also move entries between those states, one entry per read state and
// write state, since the entry memory has one read and one write port.
// req.ready is high again once the response loads, so the engine takes no
// new request until the previous one is through.
// The output register lets the next request in while a response still waits;
// if rsp.ready stays low the engine holds its finished result until the
// register frees. Reset empties the list; entry contents are not cleared.
module indexed_list_engine (
    input  logic      clk,
    input  logic      rst_n,
    ile_req_if.sink   req,
    ile_rsp_if.source rsp
);
    import ile_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ile_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    ile_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Only one request is in progress at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another was in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        sts.occ <= CNT_W'(DEPTH))
        else $error("occupancy beyond list depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (sts.occ != $past(sts.occ)) |-> $past(cmd.occ_inc || cmd.occ_dec))
        else $error("occupancy changed without a command");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && sts.fault) |=> (rsp.read_data == '0 && rsp.fault))
        else $error("refused request returned data");
endmodule
